// ===== hdl/scd_pkg.sv =====
// ---------------------------------------------------------------------------
// Sector cache clock directory package
// Shared widths, request codes and item types for the directory block.
// ---------------------------------------------------------------------------
package scd_pkg;

    localparam int SLOT_W    = 6;
    localparam int NUM_SLOTS = 1 << SLOT_W;
    localparam int CNT_W     = SLOT_W + 1;
    localparam int SECTOR_W  = 32;
    localparam int FUNC_W    = 2;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SECTOR_W-1:0] sector;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                fill_needed;
        logic                writeback_needed;
        logic [SECTOR_W-1:0] writeback_sector;
        logic                last;
    } t_rsp;

endpackage

// ===== hdl/sector_cache_clock_directory_top.sv =====
// ---------------------------------------------------------------------------
// Sector cache clock directory
// Tag directory and clock replacement for a fully associative write-back
// cache of disk sectors, run by a small sequencer over one tag memory read port.
// ---------------------------------------------------------------------------
//  channel    ports                    handshake
//  request    i_req (t_req)            taken when start is high and busy is low
//  result     o_rsp (t_rsp)            valid for one cycle while o_strobe is high
//
//  Read or write: a tag scan over the filled slots (one compare per memory
//  read); on a miss, a fill of a free slot or, when the cache is full, a
//  clock sweep over the slots from the hand and an emit state for the victim.
//  Flush: clean slots are passed over and each dirty slot is reported.
//  The single tag memory read port sets the pace of these steps.
//  Reset clears the dirty and reference bits, the fill count and the hand.
//  Results cannot be stalled; busy stays high until the last one is shown.
// ---------------------------------------------------------------------------
module sector_cache_clock_directory_top
    import scd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SWEEP,
        S_VEMIT,
        S_FSCAN,
        S_FEMIT
    } t_state;

    t_state r_state, n_state;
    logic                 r_strobe, n_strobe;
    t_rsp                 r_rsp, n_rsp;
    logic [NUM_SLOTS-1:0] r_dirty, n_dirty;
    logic [NUM_SLOTS-1:0] r_ref, n_ref;
    logic [CNT_W-1:0]     r_filled, n_filled;
    logic [SLOT_W-1:0]    r_hand, n_hand;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [SECTOR_W-1:0]  r_sector, n_sector;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [SLOT_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0]    r_sw, n_sw;
    logic [SLOT_W-1:0]    r_j, n_j;

    logic [SECTOR_W-1:0]  r_tags [NUM_SLOTS];
    logic [SECTOR_W-1:0]  r_tag_q;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [SLOT_W-1:0]    wr_addr;

    logic [NUM_SLOTS-1:0] fill_mask;
    logic [NUM_SLOTS-1:0] above_mask;
    logic                 is_write;
    logic                 any_dirty;
    logic                 more_dirty;
    logic                 victim_dirty;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            fill_mask[i]  = CNT_W'(i) < r_filled;
            above_mask[i] = SLOT_W'(i) > r_idx[SLOT_W-1:0];
        end
    end

    assign is_write     = (r_func == FUNC_WRITE);
    assign any_dirty    = |(r_dirty & fill_mask);
    assign more_dirty   = |(r_dirty & fill_mask & above_mask);
    assign victim_dirty = r_dirty[r_sw];

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        n_dirty   = r_dirty;
        n_ref     = r_ref;
        n_filled  = r_filled;
        n_hand    = r_hand;
        n_func    = r_func;
        n_sector  = r_sector;
        n_idx     = r_idx;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = r_cmp_vld;
        n_sw      = r_sw;
        n_j       = r_j;
        rd_addr   = r_idx[SLOT_W-1:0];
        mem_we    = 1'b0;
        wr_addr   = r_sw;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func    = i_req.func;
                    n_sector  = i_req.sector;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_rsp     = '0;
                    n_rsp.last = 1'b1;
                    case (i_req.func)
                        FUNC_READ, FUNC_WRITE: begin
                            n_state = S_LOOKUP;
                        end
                        FUNC_FLUSH: begin
                            if (any_dirty) begin
                                n_state = S_FSCAN;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_LOOKUP: begin
                // The tag read issued last cycle is compared while the next is issued.
                rd_addr = r_idx[SLOT_W-1:0];
                if (r_cmp_vld && r_tag_q == r_sector) begin
                    if (is_write) begin
                        n_dirty[r_cmp_idx] = 1'b1;
                    end
                    n_rsp      = '0;
                    n_rsp.slot = r_cmp_idx;
                    n_rsp.hit  = 1'b1;
                    n_rsp.last = 1'b1;
                    n_strobe   = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_idx < r_filled) begin
                    n_cmp_idx = r_idx[SLOT_W-1:0];
                    n_cmp_vld = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else if (r_filled < CNT_W'(NUM_SLOTS)) begin
                    mem_we  = 1'b1;
                    wr_addr = r_filled[SLOT_W-1:0];
                    n_ref[r_filled[SLOT_W-1:0]]   = 1'b0;
                    n_dirty[r_filled[SLOT_W-1:0]] = is_write;
                    n_filled          = r_filled + 1'b1;
                    n_rsp             = '0;
                    n_rsp.slot        = r_filled[SLOT_W-1:0];
                    n_rsp.fill_needed = !is_write;
                    n_rsp.last        = 1'b1;
                    n_strobe          = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_sw    = r_hand;
                    n_j     = '0;
                    n_state = S_SWEEP;
                end
            end

            S_SWEEP: begin
                // The tag of the slot under the hand is read every step, so the
                // victim's old tag is ready when the sweep stops.
                rd_addr = r_sw;
                if (!r_ref[r_sw]) begin
                    n_ref[r_sw] = 1'b1;
                    n_hand      = r_sw;
                    n_state     = S_VEMIT;
                end else begin
                    n_ref[r_sw] = 1'b0;
                    if (r_j == SLOT_W'(NUM_SLOTS - 1)) begin
                        n_hand  = r_sw;
                        n_state = S_VEMIT;
                    end else begin
                        n_sw = r_sw + 1'b1;
                        n_j  = r_j + 1'b1;
                    end
                end
            end

            S_VEMIT: begin
                mem_we                 = 1'b1;
                wr_addr                = r_sw;
                n_dirty[r_sw]          = is_write;
                n_rsp                  = '0;
                n_rsp.slot             = r_sw;
                n_rsp.fill_needed      = !is_write;
                n_rsp.writeback_needed = victim_dirty;
                n_rsp.writeback_sector = victim_dirty ? r_tag_q : '0;
                n_rsp.last             = 1'b1;
                n_strobe               = 1'b1;
                n_state                = S_IDLE;
            end

            S_FSCAN: begin
                rd_addr = r_idx[SLOT_W-1:0];
                if (r_dirty[r_idx[SLOT_W-1:0]]) begin
                    n_state = S_FEMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_FEMIT: begin
                n_dirty[r_idx[SLOT_W-1:0]] = 1'b0;
                n_rsp                  = '0;
                n_rsp.slot             = r_idx[SLOT_W-1:0];
                n_rsp.writeback_needed = 1'b1;
                n_rsp.writeback_sector = r_tag_q;
                n_rsp.last             = !more_dirty;
                n_strobe               = 1'b1;
                if (more_dirty) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FSCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_dirty  <= '0;
            r_ref    <= '0;
            r_filled <= '0;
            r_hand   <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_dirty  <= n_dirty;
            r_ref    <= n_ref;
            r_filled <= n_filled;
            r_hand   <= n_hand;
        end
        r_rsp     <= n_rsp;
        r_func    <= n_func;
        r_sector  <= n_sector;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_cmp_vld <= n_cmp_vld;
        r_sw      <= n_sw;
        r_j       <= n_j;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tags[wr_addr] <= r_sector;
        end
        r_tag_q <= r_tags[rd_addr];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.last |-> !busy)
        else $error("busy still high after the last result of an item");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_rsp.last |-> busy)
        else $error("sequencer went idle before the last result");

    a_accept_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strobe)
        else $error("accepted item neither started work nor produced a result");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.hit |-> !o_rsp.fill_needed && !o_rsp.writeback_needed)
        else $error("hit result asks for a fill or a write-back");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(NUM_SLOTS))
        else $error("fill count beyond the number of slots");

endmodule
